### rtl/core/integer_matrix_multiply_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integer matrix multiplier
// Concurrent checks on the rising clock edge, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef INTEGER_MATRIX_MULTIPLY_TOP_MACROS_SVH
`define INTEGER_MATRIX_MULTIPLY_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define IMM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define IMM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define IMM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define IMM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

### rtl/core/imm_pkg.sv
// ----------------------------------------------------------------------------
// imm_pkg
// Shared widths, register codes, pipeline tag type and dimension clamp.
// ----------------------------------------------------------------------------
package imm_pkg;

  localparam int MAX_DIM_DEF = 8;
  localparam int CFG_W       = 4;   // dimension register width
  localparam int ADDR_W      = 4;   // APB byte address width
  localparam int DATA_W      = 32;  // APB data width
  localparam int ELEM_W      = 16;  // input element width
  localparam int MUL_W       = 32;  // element product width
  localparam int PROD_W      = 35;  // dot product width
  localparam int IDX_W       = 3;   // row / column index width

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_A_ROWS = 2'd0;
  localparam logic [1:0] REG_A_COLS = 2'd1;
  localparam logic [1:0] REG_B_ROWS = 2'd2;
  localparam logic [1:0] REG_B_COLS = 2'd3;

  // Tag that travels with each multiply-accumulate step
  typedef struct packed {
    logic             valid;
    logic             err;
    logic             first;
    logic             last;
    logic             last_run;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } mac_tag_t;

  // Clamp a dimension register: zero acts as one, large values as the maximum
  function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v,
                                               input int max_dim);
    logic [CFG_W-1:0] lim;
    lim = CFG_W'(max_dim);
    if (v == '0) begin
      return CFG_W'(1);
    end else if (v > lim) begin
      return lim;
    end
    return v;
  endfunction

endpackage

### rtl/core/imm_ram.sv
// ----------------------------------------------------------------------------
// imm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module imm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/imm_mac.sv
// ----------------------------------------------------------------------------
// imm_mac
// Shared multiply-accumulate unit with the result output register.
// ----------------------------------------------------------------------------
`include "integer_matrix_multiply_top_macros.svh"

module imm_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  imm_pkg::mac_tag_t                   tag_in,
  input  logic signed [imm_pkg::ELEM_W-1:0]   a_data,
  input  logic signed [imm_pkg::ELEM_W-1:0]   b_data,
  output logic                                strobe,
  output logic signed [imm_pkg::PROD_W-1:0]   product_value,
  output logic        [imm_pkg::IDX_W-1:0]    out_row,
  output logic        [imm_pkg::IDX_W-1:0]    out_col,
  output logic                                last_of_run,
  output logic                                dim_error
);

  localparam int EXT_W = imm_pkg::PROD_W - imm_pkg::MUL_W;

  imm_pkg::mac_tag_t                  tag_s2;
  logic signed [imm_pkg::MUL_W-1:0]   prod;
  logic signed [imm_pkg::PROD_W-1:0]  acc;
  logic signed [imm_pkg::PROD_W-1:0]  sum;

  // Add the product to the running sum, restarting on the first term
  assign sum = (tag_s2.first ? '0 : acc) + {{EXT_W{prod[imm_pkg::MUL_W-1]}}, prod};

  // Multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_s2 <= '0;
    end else begin
      tag_s2 <= tag_in;
    end
    prod <= a_data * b_data;
  end

  // Accumulate stage and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= tag_s2.valid && (tag_s2.err || tag_s2.last);
    end
    if (tag_s2.valid) begin
      if (tag_s2.err) begin
        product_value <= '0;
        out_row       <= '0;
        out_col       <= '0;
        last_of_run   <= 1'b1;
        dim_error     <= 1'b1;
      end else if (tag_s2.last) begin
        product_value <= sum;
        out_row       <= tag_s2.row;
        out_col       <= tag_s2.col;
        last_of_run   <= tag_s2.last_run;
        dim_error     <= 1'b0;
      end else begin
        acc <= sum;
      end
    end
  end

  `IMM_ASSERT_IMP(a_err_is_last, clk, rst, strobe && dim_error, last_of_run, "error result without last")
  `IMM_ASSERT_IMP(a_err_zero, clk, rst, strobe && dim_error, product_value == '0, "error result with data")
  `IMM_ASSERT_IMP(a_strobe_src, clk, rst, strobe, $past(tag_s2.valid), "result without a step")

endmodule

### rtl/core/integer_matrix_multiply_top.sv
// ----------------------------------------------------------------------------
// integer_matrix_multiply_top: loads A then B, one element per cycle when idle.
// Last B element: busy for a_rows*b_cols*a_cols MAC steps (one MAC per cycle in
// the shared unit); results in row-major order, the last one after busy drops.
// Dimension mismatch: one error result through tag_s1, tag_s2 and strobe, no stall.
// Synchronous reset: registers to 8, load count to 0, stores left undefined.
// ----------------------------------------------------------------------------
`include "integer_matrix_multiply_top_macros.svh"

module integer_matrix_multiply_top #(
  parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // command side
  input  logic                                start,
  output logic                                busy,
  input  logic signed [imm_pkg::ELEM_W-1:0]   element_value,
  // results
  output logic                                strobe,
  output logic signed [imm_pkg::PROD_W-1:0]   product_value,
  output logic        [imm_pkg::IDX_W-1:0]    out_row,
  output logic        [imm_pkg::IDX_W-1:0]    out_col,
  output logic                                last_of_run,
  output logic                                dim_error,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic        [imm_pkg::ADDR_W-1:0]   paddr,
  input  logic        [imm_pkg::DATA_W-1:0]   pwdata,
  output logic        [imm_pkg::DATA_W-1:0]   prdata,
  output logic                                pready
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LC_W  = $clog2(2 * DEPTH + 1);
  localparam int CW    = imm_pkg::CFG_W;
  localparam int IW    = imm_pkg::IDX_W;

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t state;

  // configuration registers
  logic [CW-1:0] a_rows, a_cols, b_rows, b_cols;
  logic [CW-1:0] ar, ac, br, bc;

  // load and sequencer state
  logic [LC_W-1:0] load_count;
  logic [IW-1:0]   i_cnt, j_cnt, k_cnt;
  logic [AW-1:0]   a_addr, b_addr, a_row_base;

  imm_pkg::mac_tag_t tag_s1, tag_issue;

  logic            cfg_wr, accept, mismatch, run;
  logic [LC_W-1:0] a_total, total, lc_eff, lc_inc, lc_b;
  logic            in_a, a_we, b_we, run_start;
  logic            k_last, j_last, i_last;
  logic [imm_pkg::ELEM_W-1:0] a_rdata, b_rdata;

  // Effective dimensions
  assign ar = imm_pkg::eff_dim(a_rows, MAX_DIM);
  assign ac = imm_pkg::eff_dim(a_cols, MAX_DIM);
  assign br = imm_pkg::eff_dim(b_rows, MAX_DIM);
  assign bc = imm_pkg::eff_dim(b_cols, MAX_DIM);

  assign run      = (state == S_RUN);
  assign busy     = run;
  assign accept   = start && !busy;
  assign mismatch = (ac != br);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;

  // Load position of the incoming element
  assign a_total = LC_W'(ar) * LC_W'(ac);
  assign total   = a_total + LC_W'(br) * LC_W'(bc);
  assign lc_eff  = (load_count >= total) ? '0 : load_count;
  assign lc_inc  = lc_eff + LC_W'(1);
  assign lc_b    = lc_eff - a_total;
  assign in_a    = (lc_eff < a_total);
  assign a_we    = accept && !mismatch && in_a;
  assign b_we    = accept && !mismatch && !in_a;
  assign run_start = accept && !mismatch && (lc_inc == total);

  // Loop ends of the sequencer
  assign k_last = ({1'b0, k_cnt} == ac - CW'(1));
  assign j_last = ({1'b0, j_cnt} == bc - CW'(1));
  assign i_last = ({1'b0, i_cnt} == ar - CW'(1));

  // Step tag: a multiply step while running, an error result when idle
  always_comb begin
    tag_issue          = '0;
    tag_issue.valid    = run || (accept && mismatch);
    tag_issue.err      = !run;
    tag_issue.first    = (k_cnt == '0);
    tag_issue.last     = k_last;
    tag_issue.last_run = i_last && j_last;
    tag_issue.row      = i_cnt;
    tag_issue.col      = j_cnt;
  end

  // Register read back
  always_comb begin
    case (paddr[3:2])
      imm_pkg::REG_A_ROWS: prdata = imm_pkg::DATA_W'(a_rows);
      imm_pkg::REG_A_COLS: prdata = imm_pkg::DATA_W'(a_cols);
      imm_pkg::REG_B_ROWS: prdata = imm_pkg::DATA_W'(b_rows);
      imm_pkg::REG_B_COLS: prdata = imm_pkg::DATA_W'(b_cols);
      default:             prdata = '0;
    endcase
  end

  // State, configuration, load count and sequencer counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      a_rows     <= CW'(8);
      a_cols     <= CW'(8);
      b_rows     <= CW'(8);
      b_cols     <= CW'(8);
      load_count <= '0;
      i_cnt      <= '0;
      j_cnt      <= '0;
      k_cnt      <= '0;
      a_addr     <= '0;
      b_addr     <= '0;
      a_row_base <= '0;
      tag_s1     <= '0;
    end else begin
      tag_s1 <= tag_issue;
      case (state)
        S_IDLE: begin
          if (accept && !mismatch && !cfg_wr) begin
            load_count <= run_start ? '0 : lc_inc;
          end
          if (run_start) begin
            state      <= S_RUN;
            i_cnt      <= '0;
            j_cnt      <= '0;
            k_cnt      <= '0;
            a_addr     <= '0;
            b_addr     <= '0;
            a_row_base <= '0;
          end
        end
        S_RUN: begin
          // advance over k, then j, then i
          if (!k_last) begin
            k_cnt  <= k_cnt + IW'(1);
            a_addr <= a_addr + AW'(1);
            b_addr <= b_addr + AW'(bc);
          end else begin
            k_cnt <= '0;
            if (!j_last) begin
              j_cnt  <= j_cnt + IW'(1);
              a_addr <= a_row_base;
              b_addr <= AW'(j_cnt) + AW'(1);
            end else begin
              j_cnt      <= '0;
              b_addr     <= '0;
              i_cnt      <= i_cnt + IW'(1);
              a_row_base <= a_row_base + AW'(ac);
              a_addr     <= a_row_base + AW'(ac);
              if (i_last) begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      // register write restarts loading
      if (cfg_wr) begin
        load_count <= '0;
        case (paddr[3:2])
          imm_pkg::REG_A_ROWS: a_rows <= pwdata[CW-1:0];
          imm_pkg::REG_A_COLS: a_cols <= pwdata[CW-1:0];
          imm_pkg::REG_B_ROWS: b_rows <= pwdata[CW-1:0];
          imm_pkg::REG_B_COLS: b_cols <= pwdata[CW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Element stores
  imm_ram #(.WIDTH(imm_pkg::ELEM_W), .DEPTH(DEPTH)) u_a_store (
    .clk   (clk),
    .we    (a_we),
    .waddr (lc_eff[AW-1:0]),
    .wdata (element_value),
    .raddr (a_addr),
    .rdata (a_rdata)
  );

  imm_ram #(.WIDTH(imm_pkg::ELEM_W), .DEPTH(DEPTH)) u_b_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (lc_b[AW-1:0]),
    .wdata (element_value),
    .raddr (b_addr),
    .rdata (b_rdata)
  );

  // Shared multiply-accumulate unit
  imm_mac u_mac (
    .clk           (clk),
    .rst           (rst),
    .tag_in        (tag_s1),
    .a_data        (a_rdata),
    .b_data        (b_rdata),
    .strobe        (strobe),
    .product_value (product_value),
    .out_row       (out_row),
    .out_col       (out_col),
    .last_of_run   (last_of_run),
    .dim_error     (dim_error)
  );

  `IMM_ASSERT_IMP(a_run_lc_zero, clk, rst, busy, load_count == '0, "load count live while busy")
  `IMM_ASSERT_IMP(a_no_store_run, clk, rst, busy, !a_we && !b_we, "store write while busy")
  `IMM_ASSERT_NXT(a_enter_run, clk, rst, run_start, busy, "full load did not start compute")
  `IMM_ASSERT_IMP(a_err_src, clk, rst, tag_s1.valid && tag_s1.err, $past(start && !busy), "error step without transfer")

endmodule
